### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge, off while reset is active
`define ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error(msg);

// signal held low while reset stays active, not checked on the edge where reset is first seen
`define ASSERT_LOW_IN_RESET(lbl, clk_sig, rst_n_sig, sig, msg) \
	lbl: assert property (@(posedge clk_sig) \
		(!rst_n_sig && $past(!rst_n_sig)) |-> !(sig)) \
		else $error(msg);

`endif

### rtl/mscrc_pkg.sv
// ----------------------------------------------------------------------------
// mscrc_pkg
// shared types and constants of the multi-standard crc engine
// ----------------------------------------------------------------------------
package mscrc_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CRC_W    = 32;

	typedef enum logic [OP_W-1:0] {
		STD_J1850 = 2'd0,
		STD_H2F   = 2'd1,
		STD_CCITT = 2'd2,
		STD_CRC32 = 2'd3
	} crc_std_t;

	localparam logic [7:0]       POLY_J1850      = 8'h1D;
	localparam logic [7:0]       POLY_H2F        = 8'h2F;
	localparam logic [15:0]      POLY_CCITT      = 16'h1021;
	localparam logic [CRC_W-1:0] POLY_CRC32_REFL = 32'hEDB8_8320;

	localparam logic [CRC_W-1:0] INIT_CRC8  = 32'h0000_00FF;
	localparam logic [CRC_W-1:0] INIT_CRC16 = 32'h0000_FFFF;
	localparam logic [CRC_W-1:0] INIT_CRC32 = 32'hFFFF_FFFF;

	localparam logic [7:0]       XOROUT_CRC8  = 8'hFF;
	localparam logic [CRC_W-1:0] XOROUT_CRC32 = 32'hFFFF_FFFF;

endpackage

### rtl/mscrc_fold.sv
// ----------------------------------------------------------------------------
// mscrc_fold
// one-byte crc update, eight unrolled shift steps per standard
// ----------------------------------------------------------------------------
module mscrc_fold (
	input  logic [mscrc_pkg::OP_W-1:0]   op,
	input  logic [mscrc_pkg::BYTE_W-1:0] data_byte,
	input  logic                         first_byte,
	input  logic [mscrc_pkg::CRC_W-1:0]  rem,
	output logic [mscrc_pkg::CRC_W-1:0]  next_rem,
	output logic [mscrc_pkg::CRC_W-1:0]  crc_value
);
	import mscrc_pkg::*;

	crc_std_t         std;
	logic [CRC_W-1:0] base;
	logic [7:0]       poly8;
	logic [7:0]       r8;
	logic [15:0]      r16;
	logic [CRC_W-1:0] r32;

	assign std = crc_std_t'(op);

	// start value: init on a first byte, else the kept remainder
	always_comb begin
		base = rem;
		if (first_byte) begin
			unique case (std)
				STD_CCITT: base = INIT_CRC16;
				STD_CRC32: base = INIT_CRC32;
				default:   base = INIT_CRC8;
			endcase
		end
	end

	assign poly8 = (std == STD_H2F) ? POLY_H2F : POLY_J1850;

	// msb-first crc8
	always_comb begin
		r8 = base[7:0] ^ data_byte;
		for (int i = 0; i < 8; i++) begin
			r8 = r8[7] ? ({r8[6:0], 1'b0} ^ poly8) : {r8[6:0], 1'b0};
		end
	end

	// msb-first crc16
	always_comb begin
		r16 = base[15:0] ^ {data_byte, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r16 = r16[15] ? ({r16[14:0], 1'b0} ^ POLY_CCITT) : {r16[14:0], 1'b0};
		end
	end

	// reflected crc32
	always_comb begin
		r32 = base ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
		for (int i = 0; i < 8; i++) begin
			r32 = r32[0] ? ({1'b0, r32[CRC_W-1:1]} ^ POLY_CRC32_REFL) : {1'b0, r32[CRC_W-1:1]};
		end
	end

	always_comb begin
		unique case (std)
			STD_J1850, STD_H2F: begin
				next_rem  = {24'h0, r8};
				crc_value = {24'h0, r8 ^ XOROUT_CRC8};
			end
			STD_CCITT: begin
				next_rem  = {16'h0, r16};
				crc_value = {16'h0, r16};
			end
			default: begin
				next_rem  = r32;
				crc_value = r32 ^ XOROUT_CRC32;
			end
		endcase
	end

endmodule

### rtl/multi_standard_crc_engine_core.sv
// ----------------------------------------------------------------------------
// multi_standard_crc_engine_core
// byte-wide crc engine for crc8 j1850, crc8 h2f, crc16 ccitt and crc32
// ----------------------------------------------------------------------------
// datapath: an accepted item enters the item register, is folded there and,
//   if last, its crc is captured in the result register that drives out_valid
// throughput: one item per cycle, set by the combinational byte fold against
//   the kept remainder register; a last item waits only while an undrained
//   crc holds the result register
// reset: arst_n clears the item valid, the output valid and the remainder
//   to zero; a message that starts without first_byte folds from zero
module multi_standard_crc_engine_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mscrc_pkg::OP_W-1:0]   op,
	input  logic [mscrc_pkg::BYTE_W-1:0] data_byte,
	input  logic                         first_byte,
	input  logic                         last_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mscrc_pkg::CRC_W-1:0]  crc_value
);
	import mscrc_pkg::*;

	// item register
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              first_s1;
	logic              last_s1;

	// kept remainder and result register
	logic [CRC_W-1:0]  rem_q;
	logic              out_valid_q;
	logic [CRC_W-1:0]  crc_q;

	logic [CRC_W-1:0]  next_rem;
	logic [CRC_W-1:0]  fold_crc;
	logic              out_free;
	logic              go_s1;

	// result register can take a new crc when empty or being drained
	assign out_free = !out_valid_q || out_ready;
	// items without last_byte never need the result register
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload of the item register, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op;
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	mscrc_fold u_fold (
		.op         (op_s1),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.rem        (rem_q),
		.next_rem   (next_rem),
		.crc_value  (fold_crc)
	);

	// remainder advances once per item, in arrival order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (go_s1) begin
			rem_q <= next_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			crc_q <= fold_crc;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

	`include "assert_macros.svh"

	// a result only appears right after a last item was folded
	`ASSERT_CLK(a_out_from_last, clk, arst_n, $rose(out_valid_q) |-> $past(go_s1 && last_s1), "result without last item")
	// the item register stalls only for a last item facing a full output
	`ASSERT_CLK(a_stall_reason, clk, arst_n, (valid_s1 && !go_s1) |-> (last_s1 && out_valid_q && !out_ready), "item stalled without cause")
	// crc8 leaves the upper remainder bits clear
	`ASSERT_CLK(a_crc8_width, clk, arst_n, (go_s1 && (op_s1 == STD_J1850 || op_s1 == STD_H2F)) |=> (rem_q[CRC_W-1:8] == '0), "crc8 remainder too wide")
	`ASSERT_LOW_IN_RESET(a_reset_out, clk, arst_n, out_valid_q, "output valid during reset")

endmodule

### tb/sv/crc_engine_checker.sv
// ----------------------------------------------------------------------------
// crc_engine_checker
// watches both channels of the crc engine and checks every emitted crc
// against a crc computed here from the accepted bytes.
// ----------------------------------------------------------------------------
module crc_engine_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [mscrc_pkg::OP_W-1:0]   op,
	input  logic [mscrc_pkg::BYTE_W-1:0] data_byte,
	input  logic                         first_byte,
	input  logic                         last_byte,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [mscrc_pkg::CRC_W-1:0]  crc_value,
	output int                           mismatch_count,
	output int                           pending_count,
	output int                           crc_checked
);

	timeunit 1ns;
	timeprecision 1ps;

	import mscrc_pkg::*;

	typedef struct {
		crc_std_t         std;
		logic [CRC_W-1:0] crc;
	} crc_expect_t;

	crc_expect_t      expected_crcs[$];
	logic [CRC_W-1:0] crc_remainder;
	int               fails;
	int               checked;

	// next remainder after one byte, init loaded first when the byte opens a message
	function automatic logic [CRC_W-1:0] fold_byte(crc_std_t std, logic [CRC_W-1:0] rem,
			logic [BYTE_W-1:0] data, logic first);
		logic [CRC_W-1:0] start;
		logic [7:0]       poly8;
		logic [7:0]       r8;
		logic [15:0]      r16;
		logic [CRC_W-1:0] r32;
		start = rem;
		if (first) begin
			case (std)
				STD_CCITT: start = INIT_CRC16;
				STD_CRC32: start = INIT_CRC32;
				default:   start = INIT_CRC8;
			endcase
		end
		case (std)
			STD_J1850, STD_H2F: begin
				poly8 = (std == STD_J1850) ? POLY_J1850 : POLY_H2F;
				r8 = start[7:0] ^ data;
				for (int i = 0; i < 8; i++)
					r8 = r8[7] ? ({r8[6:0], 1'b0} ^ poly8) : {r8[6:0], 1'b0};
				return {24'd0, r8};
			end
			STD_CCITT: begin
				r16 = start[15:0] ^ {data, 8'h00};
				for (int i = 0; i < 8; i++)
					r16 = r16[15] ? ({r16[14:0], 1'b0} ^ POLY_CCITT) : {r16[14:0], 1'b0};
				return {16'd0, r16};
			end
			default: begin
				// reflected form, lsb first
				r32 = start ^ {24'd0, data};
				for (int i = 0; i < 8; i++)
					r32 = r32[0] ? ((r32 >> 1) ^ POLY_CRC32_REFL) : (r32 >> 1);
				return r32;
			end
		endcase
	endfunction

	function automatic logic [CRC_W-1:0] final_crc(crc_std_t std, logic [CRC_W-1:0] rem);
		case (std)
			STD_J1850, STD_H2F: return {24'd0, rem[7:0] ^ XOROUT_CRC8};
			STD_CCITT:          return {16'd0, rem[15:0]};
			default:            return rem ^ XOROUT_CRC32;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crc_expect_t      head;
		crc_std_t         std;
		logic [CRC_W-1:0] next_rem;
		if (!arst_n) begin
			crc_remainder = '0;
			expected_crcs.delete();
			fails = 0;
			checked = 0;
			mismatch_count <= 0;
			pending_count <= 0;
			crc_checked <= 0;
		end else begin
			// results leave only after their byte has passed the item and result registers, so compare before pushing
			if (out_valid && out_ready) begin
				if (expected_crcs.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("[%0t] unexpected crc %h with nothing outstanding",
							$realtime, crc_value);
				end else begin
					head = expected_crcs.pop_front();
					checked++;
					if (crc_value !== head.crc) begin
						fails++;
						if (fails <= 10)
							$display("[%0t] crc mismatch (%s): expected %h, got %h",
								$realtime, head.std.name(), head.crc, crc_value);
					end
				end
			end
			if (in_valid && in_ready) begin
				std = crc_std_t'(op);
				next_rem = fold_byte(std, crc_remainder, data_byte, first_byte);
				crc_remainder = next_rem;
				if (last_byte)
					expected_crcs.push_back('{std: std, crc: final_crc(std, next_rem)});
			end
			mismatch_count <= fails;
			pending_count <= expected_crcs.size();
			crc_checked <= checked;
		end
	end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives byte items into the multi-standard crc engine: a directed opening
// for the corner cases of each standard, then random messages with bursty
// input and a stalling output side. the checker decides every crc.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import mscrc_pkg::*;

	localparam int ITEM_TARGET = 1550;
	localparam int DRAIN_LIMIT = 5000;   // cycles allowed for outstanding crcs
	localparam int TAIL_CYCLES = 10;     // extra cycles to watch for stray crcs after the drain

	// output side stall styles
	typedef enum int {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic [OP_W-1:0]   op         = '0;
	logic [BYTE_W-1:0] data_byte  = '0;
	logic              first_byte = 1'b0;
	logic              last_byte  = 1'b0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [CRC_W-1:0]  crc_value;

	int mismatch_count;
	int pending_count;
	int crc_checked;

	int items_sent = 0;
	int burst_left = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	multi_standard_crc_engine_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.crc_value  (crc_value)
	);

	crc_engine_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.data_byte      (data_byte),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.crc_value      (crc_value),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.crc_checked    (crc_checked)
	);

	// present one byte item, hold it until taken, then maybe idle before the next;
	// the sender runs in bursts with random gaps between them
	task automatic send_item(crc_std_t std, logic [BYTE_W-1:0] data, logic first, logic last);
		int gap;
		in_valid <= 1'b1;
		op <= std;
		data_byte <= data;
		first_byte <= first;
		last_byte <= last;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end of burst: pick a gap, mostly short, sometimes long
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 5);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// output side: stall style changes every so often, including long stretches
	// where the engine is never held up
	initial begin
		rx_mode_t mode;
		int       span;
		wait (arst_n === 1'b1);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 200);
			for (int tick = 0; tick < span; tick++) begin
				@(posedge clk);
				case (mode)
					RX_ALWAYS:   out_ready <= 1'b1;
					RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: out_ready <= ((tick % 5) < 2);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		int       choice;
		int       len;
		int       waited;
		crc_std_t std;
		crc_std_t alt;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening
		// byte with no first flag right after reset folds from a zero remainder
		send_item(STD_J1850, 8'h00, 1'b0, 1'b0);
		send_item(STD_J1850, 8'hFF, 1'b0, 1'b1);
		// single-byte messages on every standard, mostly data extremes
		send_item(STD_H2F,   8'hA5, 1'b1, 1'b1);
		send_item(STD_CCITT, 8'h00, 1'b1, 1'b1);
		send_item(STD_CRC32, 8'hFF, 1'b1, 1'b1);
		send_item(STD_J1850, 8'h00, 1'b1, 1'b1);
		send_item(STD_H2F,   8'hFF, 1'b1, 1'b1);
		// short multi-byte messages
		send_item(STD_CCITT, 8'hFF, 1'b1, 1'b0);
		send_item(STD_CCITT, 8'h5A, 1'b0, 1'b1);
		send_item(STD_CRC32, 8'h00, 1'b1, 1'b0);
		send_item(STD_CRC32, 8'h80, 1'b0, 1'b0);
		send_item(STD_CRC32, 8'h01, 1'b0, 1'b1);
		// carry on after the last byte without a new first byte
		send_item(STD_CRC32, 8'h7E, 1'b0, 1'b1);
		// switch standard mid-message: wide remainder narrowed, then widened again
		send_item(STD_CCITT, 8'h3C, 1'b0, 1'b1);
		send_item(STD_J1850, 8'hC3, 1'b0, 1'b0);
		send_item(STD_CRC32, 8'h55, 1'b0, 1'b1);
		// swap between the two crc8 polynomials
		send_item(STD_H2F,   8'hFF, 1'b1, 1'b0);
		send_item(STD_J1850, 8'h0F, 1'b0, 1'b1);
		send_item(STD_CRC32, 8'hAA, 1'b0, 1'b0);
		send_item(STD_H2F,   8'h12, 1'b0, 1'b1);

		// random part: mostly proper messages, some broken ones and loose noise
		while (items_sent < ITEM_TARGET) begin
			choice = $urandom_range(0, 99);
			std = crc_std_t'($urandom_range(0, 3));
			alt = crc_std_t'($urandom_range(0, 3));
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			if (choice < 80) begin
				for (int k = 0; k < len; k++)
					send_item(std, 8'($urandom_range(0, 255)), k == 0, k == len - 1);
			end else if (choice < 85) begin
				// continues from whatever remainder is left over
				for (int k = 0; k < len; k++)
					send_item(std, 8'($urandom_range(0, 255)), 1'b0, k == len - 1);
			end else if (choice < 90) begin
				// standard changes halfway through
				for (int k = 0; k < len; k++)
					send_item((k < len / 2) ? std : alt, 8'($urandom_range(0, 255)),
						k == 0, k == len - 1);
			end else begin
				for (int k = 0; k < len; k++)
					send_item(crc_std_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);

		// let every outstanding crc come out, then watch for strays
		waited = 0;
		while (pending_count != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_count != 0)
			$display("%0d expected crc results never arrived", pending_count);
		$display("%0d byte items over all four standards, %0d crc results compared",
			items_sent, crc_checked);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// safety net far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("timeout waiting for the engine");
		$display("Test completed with failures");
		$finish;
	end

endmodule
